@@ rtl/core/acir_pkg.sv @@
// Shared widths, constants, types and helpers of the box contact resolver.
package acir_pkg;

    localparam int FRAC_W   = 16;
    localparam int WORD_W   = 32;
    localparam int REACH_W  = 31;
    localparam int MASS_W   = 31;
    localparam int BOUNCE_W = 17;
    localparam int GRIP_W   = 19;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 2;

    localparam int OV_W     = WORD_W + 1;
    localparam int DEPTH_W  = REACH_W;
    localparam int E1_W     = BOUNCE_W + 1;
    localparam int NUM_W    = 50;
    localparam int DEN_W    = 32;
    localparam int GPROD_W  = 2 * GRIP_W;
    localparam int ROOT_W   = GPROD_W / 2;
    localparam int SPLIT_W  = 25;
    localparam int HI_W     = NUM_W - SPLIT_W;
    localparam int PJM_W    = SPLIT_W + ROOT_W;
    localparam int LIMF_W   = HI_W + ROOT_W + SPLIT_W;
    localparam int LIM_W    = LIMF_W - FRAC_W;
    localparam int PP_W     = MASS_W + SPLIT_W;
    localparam int PROD_W   = 64;
    localparam int MAG_W    = PROD_W - FRAC_W;
    localparam int LANES    = 6;

    localparam int DIV_LAT  = NUM_W;
    localparam int SQRT_LAT = ROOT_W;
    localparam int MU_PAD   = DIV_LAT - SQRT_LAT;

    localparam logic [CFG_W-1:0]  PERCENT_RST = 17'd26214;
    localparam logic [CFG_W-1:0]  SLOP_RST    = 17'd655;
    localparam logic [WORD_W-1:0] TANGENT_EPS = 32'd6;
    localparam logic [E1_W-1:0]   ONE_Q16     = 18'h10000;

    localparam logic [WORD_W-1:0] MAX_POS = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] MIN_NEG = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERCENT = 2'd0,
        CFG_SLOP    = 2'd1
    } t_cfg_idx;

    // Per-item control that rides alongside the dividers.
    typedef struct packed {
        logic              ok;
        logic              contact;
        logic              approach;
        logic              fric_en;
        logic              fneg;
        logic              n_is_y;
        logic              nneg;
        logic [MASS_W-1:0] inv_a;
        logic [MASS_W-1:0] inv_b;
    } t_side;

    typedef struct packed {
        t_side              side;
        logic [NUM_W-1:0]   num_j;
        logic [NUM_W-1:0]   num_f;
        logic [NUM_W-1:0]   num_c;
        logic [DEN_W-1:0]   den;
        logic [GPROD_W-1:0] gprod;
    } t_prep;

    typedef struct packed {
        logic              contact;
        logic [WORD_W-1:0] vel_a_dx;
        logic [WORD_W-1:0] vel_a_dy;
        logic [WORD_W-1:0] vel_b_dx;
        logic [WORD_W-1:0] vel_b_dy;
        logic [WORD_W-1:0] pos_a_dx;
        logic [WORD_W-1:0] pos_a_dy;
        logic [WORD_W-1:0] pos_b_dx;
        logic [WORD_W-1:0] pos_b_dy;
    } t_result;

    // Applies the sign to a magnitude and saturates to a signed word.
    function automatic logic [WORD_W-1:0] sat_signed(input logic [MAG_W-1:0] mag,
                                                     input logic neg);
        logic [WORD_W-1:0] res;
        if (!neg) begin
            res = (mag > MAG_W'(MAX_POS)) ? MAX_POS : mag[WORD_W-1:0];
        end else begin
            res = (mag > MAG_W'(MIN_NEG)) ? MIN_NEG : (~mag[WORD_W-1:0] + 1'b1);
        end
        return res;
    endfunction

endpackage

@@ rtl/core/acir_prep.sv @@
// Front stages: overlap test, normal axis choice and the three dividends.
module acir_prep (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  logic signed [31:0]            i_offset_x,
    input  logic signed [31:0]            i_offset_y,
    input  logic [30:0]                   i_reach_x,
    input  logic [30:0]                   i_reach_y,
    input  logic signed [31:0]            i_rel_vel_x,
    input  logic signed [31:0]            i_rel_vel_y,
    input  logic [30:0]                   i_inv_mass_a,
    input  logic [30:0]                   i_inv_mass_b,
    input  logic [16:0]                   i_bounce_a,
    input  logic [16:0]                   i_bounce_b,
    input  logic [18:0]                   i_grip_a,
    input  logic [18:0]                   i_grip_b,
    input  logic [acir_pkg::CFG_W-1:0]    i_percent,
    input  logic [acir_pkg::CFG_W-1:0]    i_slop,
    output logic                          o_valid,
    output acir_pkg::t_prep               o_data
);

    logic [5:0] r_v;

    // Stage 0: input register.
    logic signed [31:0] r0_off_x, r0_off_y, r0_rv_x, r0_rv_y;
    logic [30:0]        r0_reach_x, r0_reach_y, r0_inv_a, r0_inv_b;
    logic [16:0]        r0_ba, r0_bb;
    logic [18:0]        r0_ga, r0_gb;

    // Stage 1.
    logic [31:0]                      n1_abs_x, n1_abs_y, n1_den;
    logic [16:0]                      n1_e;
    logic [acir_pkg::GPROD_W-1:0]     n1_gprod;
    logic [31:0]                      r1_abs_x, r1_abs_y, r1_den;
    logic [16:0]                      r1_e;
    logic [acir_pkg::GPROD_W-1:0]     r1_gprod;
    logic [30:0]                      r1_reach_x, r1_reach_y, r1_inv_a, r1_inv_b;
    logic signed [31:0]               r1_rv_x, r1_rv_y;
    logic                             r1_neg_x, r1_neg_y;

    // Stage 2.
    logic signed [acir_pkg::OV_W-1:0] n2_ov_x, n2_ov_y, r2_ov_x, r2_ov_y;
    logic [acir_pkg::E1_W-1:0]        n2_e1, r2_e1;
    logic                             r2_den_nz;
    logic [31:0]                      r2_den;
    logic [acir_pkg::GPROD_W-1:0]     r2_gprod;
    logic signed [31:0]               r2_rv_x, r2_rv_y;
    logic                             r2_neg_x, r2_neg_y;
    logic [30:0]                      r2_inv_a, r2_inv_b;

    // Stage 3.
    logic                             n3_contact, n3_n_is_y, n3_nneg;
    logic [acir_pkg::DEPTH_W-1:0]     n3_depth, r3_depth;
    logic signed [31:0]               n3_rvn, n3_vt, r3_rvn, r3_vt;
    logic                             r3_contact, r3_n_is_y, r3_nneg, r3_den_nz;
    logic [acir_pkg::E1_W-1:0]        r3_e1;
    logic [31:0]                      r3_den;
    logic [acir_pkg::GPROD_W-1:0]     r3_gprod;
    logic [30:0]                      r3_inv_a, r3_inv_b;

    // Stage 4.
    logic signed [acir_pkg::OV_W-1:0] n4_rvn_ext, n4_mvn;
    logic                             n4_approach, n4_fneg;
    logic [31:0]                      n4_avt;
    logic [acir_pkg::DEPTH_W-1:0]     n4_excess, r4_excess;
    logic                             r4_ok, r4_contact, r4_n_is_y, r4_nneg;
    logic                             r4_approach, r4_fneg;
    logic [31:0]                      r4_negvn, r4_avt;
    logic [acir_pkg::E1_W-1:0]        r4_e1;
    logic [31:0]                      r4_den;
    logic [acir_pkg::GPROD_W-1:0]     r4_gprod;
    logic [30:0]                      r4_inv_a, r4_inv_b;

    // Stage 5: output register.
    acir_pkg::t_prep                  n5_data, r5_data;

    always_comb begin
        n1_abs_x = r0_off_x[31] ? (~r0_off_x + 32'sd1) : r0_off_x;
        n1_abs_y = r0_off_y[31] ? (~r0_off_y + 32'sd1) : r0_off_y;
        n1_den   = 32'(r0_inv_a) + 32'(r0_inv_b);
        n1_e     = (r0_ba < r0_bb) ? r0_ba : r0_bb;
        n1_gprod = acir_pkg::GPROD_W'(r0_ga) * acir_pkg::GPROD_W'(r0_gb);

        n2_ov_x  = $signed({2'b00, r1_reach_x}) - $signed({1'b0, r1_abs_x});
        n2_ov_y  = $signed({2'b00, r1_reach_y}) - $signed({1'b0, r1_abs_y});
        n2_e1    = {1'b0, r1_e} + acir_pkg::ONE_Q16;

        n3_contact = (r2_ov_x > 33'sd0) && (r2_ov_y > 33'sd0);
        n3_n_is_y  = !(r2_ov_x < r2_ov_y);
        n3_nneg    = n3_n_is_y ? r2_neg_y : r2_neg_x;
        n3_depth   = n3_n_is_y ? r2_ov_y[30:0] : r2_ov_x[30:0];
        n3_rvn     = n3_n_is_y ? r2_rv_y : r2_rv_x;
        n3_vt      = n3_n_is_y ? r2_rv_x : r2_rv_y;

        // Normal speed with the sign flipped so that approach is positive.
        n4_rvn_ext  = {r3_rvn[31], r3_rvn};
        n4_mvn      = r3_nneg ? n4_rvn_ext : -n4_rvn_ext;
        n4_approach = !n4_mvn[acir_pkg::OV_W-1] && (n4_mvn != 33'sd0);
        n4_avt      = r3_vt[31] ? (~r3_vt + 32'sd1) : r3_vt;
        n4_fneg     = !r3_vt[31] && (r3_vt != 32'sd0);
        n4_excess   = (r3_depth > acir_pkg::DEPTH_W'(i_slop))
                      ? r3_depth - acir_pkg::DEPTH_W'(i_slop) : '0;

        n5_data.side.ok       = r4_ok;
        n5_data.side.contact  = r4_contact;
        n5_data.side.approach = r4_approach;
        n5_data.side.fric_en  = r4_avt > acir_pkg::TANGENT_EPS;
        n5_data.side.fneg     = r4_fneg;
        n5_data.side.n_is_y   = r4_n_is_y;
        n5_data.side.nneg     = r4_nneg;
        n5_data.side.inv_a    = r4_inv_a;
        n5_data.side.inv_b    = r4_inv_b;
        n5_data.num_j         = acir_pkg::NUM_W'(r4_e1) * acir_pkg::NUM_W'(r4_negvn);
        n5_data.num_f         = acir_pkg::NUM_W'({r4_avt, {acir_pkg::FRAC_W{1'b0}}});
        n5_data.num_c         = acir_pkg::NUM_W'(r4_excess) * acir_pkg::NUM_W'(i_percent);
        n5_data.den           = r4_den;
        n5_data.gprod         = r4_gprod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r0_off_x   <= i_offset_x;
            r0_off_y   <= i_offset_y;
            r0_rv_x    <= i_rel_vel_x;
            r0_rv_y    <= i_rel_vel_y;
            r0_reach_x <= i_reach_x;
            r0_reach_y <= i_reach_y;
            r0_inv_a   <= i_inv_mass_a;
            r0_inv_b   <= i_inv_mass_b;
            r0_ba      <= i_bounce_a;
            r0_bb      <= i_bounce_b;
            r0_ga      <= i_grip_a;
            r0_gb      <= i_grip_b;

            r1_abs_x   <= n1_abs_x;
            r1_abs_y   <= n1_abs_y;
            r1_den     <= n1_den;
            r1_e       <= n1_e;
            r1_gprod   <= n1_gprod;
            r1_reach_x <= r0_reach_x;
            r1_reach_y <= r0_reach_y;
            r1_inv_a   <= r0_inv_a;
            r1_inv_b   <= r0_inv_b;
            r1_rv_x    <= r0_rv_x;
            r1_rv_y    <= r0_rv_y;
            r1_neg_x   <= r0_off_x[31];
            r1_neg_y   <= r0_off_y[31];

            r2_ov_x    <= n2_ov_x;
            r2_ov_y    <= n2_ov_y;
            r2_e1      <= n2_e1;
            r2_den_nz  <= (r1_den != 32'd0);
            r2_den     <= r1_den;
            r2_gprod   <= r1_gprod;
            r2_rv_x    <= r1_rv_x;
            r2_rv_y    <= r1_rv_y;
            r2_neg_x   <= r1_neg_x;
            r2_neg_y   <= r1_neg_y;
            r2_inv_a   <= r1_inv_a;
            r2_inv_b   <= r1_inv_b;

            r3_contact <= n3_contact;
            r3_n_is_y  <= n3_n_is_y;
            r3_nneg    <= n3_nneg;
            r3_depth   <= n3_depth;
            r3_rvn     <= n3_rvn;
            r3_vt      <= n3_vt;
            r3_den_nz  <= r2_den_nz;
            r3_e1      <= r2_e1;
            r3_den     <= r2_den;
            r3_gprod   <= r2_gprod;
            r3_inv_a   <= r2_inv_a;
            r3_inv_b   <= r2_inv_b;

            r4_ok       <= r3_contact && r3_den_nz;
            r4_contact  <= r3_contact;
            r4_n_is_y   <= r3_n_is_y;
            r4_nneg     <= r3_nneg;
            r4_approach <= n4_approach;
            r4_negvn    <= n4_mvn[31:0];
            r4_avt      <= n4_avt;
            r4_fneg     <= n4_fneg;
            r4_excess   <= n4_excess;
            r4_e1       <= r3_e1;
            r4_den      <= r3_den;
            r4_gprod    <= r3_gprod;
            r4_inv_a    <= r3_inv_a;
            r4_inv_b    <= r3_inv_b;

            r5_data     <= n5_data;
        end
    end

    assign o_valid = r_v[5];
    assign o_data  = r5_data;

endmodule

@@ rtl/core/acir_div.sv @@
// Pipelined restoring divider that retires one quotient bit per stage.
module acir_div #(
    parameter int NUM_W = acir_pkg::NUM_W,
    parameter int DEN_W = acir_pkg::DEN_W
) (
    input  logic             i_clk,
    input  logic             i_adv,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_nq  [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W-1:0] p_rem, p_den, n_rem;
        logic [NUM_W-1:0] p_nq, n_nq;
        logic [DEN_W:0]   trial;
        logic             ge;

        if (k == 0) begin : g_first
            assign p_rem = '0;
            assign p_nq  = i_num;
            assign p_den = i_den;
        end else begin : g_next
            assign p_rem = r_rem[k-1];
            assign p_nq  = r_nq[k-1];
            assign p_den = r_den[k-1];
        end

        always_comb begin
            trial = {p_rem, p_nq[NUM_W-1]};
            ge    = trial >= {1'b0, p_den};
            n_rem = ge ? DEN_W'(trial - {1'b0, p_den}) : trial[DEN_W-1:0];
            // The dividend shifts out the top while quotient bits fill the bottom.
            n_nq  = {p_nq[NUM_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k] <= n_rem;
                r_nq[k]  <= n_nq;
                r_den[k] <= p_den;
            end
        end
    end

    assign o_quo = r_nq[NUM_W-1];

endmodule

@@ rtl/core/acir_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
module acir_sqrt #(
    parameter int IN_W = acir_pkg::GPROD_W
) (
    input  logic                  i_clk,
    input  logic                  i_adv,
    input  logic [IN_W-1:0]       i_val,
    output logic [IN_W/2-1:0]     o_root
);

    localparam int ROOT_W = IN_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [IN_W-1:0]   r_val  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0]  p_rem, trial_rem, trial, n_rem;
        logic [ROOT_W-1:0] p_root, n_root;
        logic [IN_W-1:0]   p_val;
        logic              ge;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_val  = i_val;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_val  = r_val[k-1];
        end

        always_comb begin
            trial_rem = {p_rem[REM_W-3:0], p_val[IN_W-1:IN_W-2]};
            trial     = {p_root, 2'b01};
            ge        = trial_rem >= trial;
            n_rem     = ge ? trial_rem - trial : trial_rem;
            n_root    = {p_root[ROOT_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_val[k]  <= {p_val[IN_W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

@@ rtl/core/acir_post.sv @@
// Back stages: friction limit, impulse scaling by inverse mass and saturation.
module acir_post (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic                           i_valid,
    input  acir_pkg::t_side                i_side,
    input  logic [acir_pkg::NUM_W-1:0]     i_jn,
    input  logic [acir_pkg::NUM_W-1:0]     i_ft,
    input  logic [acir_pkg::NUM_W-1:0]     i_corr,
    input  logic [acir_pkg::ROOT_W-1:0]    i_mu,
    output logic                           o_valid,
    output acir_pkg::t_result              o_res
);

    localparam int NW = acir_pkg::NUM_W;
    localparam int SW = acir_pkg::SPLIT_W;

    logic [4:0] r_v;
    acir_pkg::t_side r1_side, r2_side, r3_side, r4_side, r5_side;

    logic [acir_pkg::PJM_W-1:0]  n1_pjm_lo, n1_pjm_hi, r1_pjm_lo, r1_pjm_hi;
    logic [NW-1:0]               r1_jn, r1_ft, r1_corr;

    logic [acir_pkg::LIMF_W-1:0] n2_full;
    logic [acir_pkg::LIM_W-1:0]  r2_limit;
    logic [NW-1:0]               r2_jn, r2_ft, r2_corr;

    logic [NW-1:0]               n3_ft, r3_jn, r3_ft, r3_corr;

    logic [acir_pkg::PP_W-1:0]   n4_lo [acir_pkg::LANES];
    logic [acir_pkg::PP_W-1:0]   n4_hi [acir_pkg::LANES];
    logic [acir_pkg::PP_W-1:0]   r4_lo [acir_pkg::LANES];
    logic [acir_pkg::PP_W-1:0]   r4_hi [acir_pkg::LANES];
    logic [NW-1:0]               mag   [3];

    logic [acir_pkg::PROD_W-1:0] n5_sum [acir_pkg::LANES];
    logic [acir_pkg::MAG_W-1:0]  r5_mag [acir_pkg::LANES];

    logic                        vel_en, fric_on;
    logic [acir_pkg::WORD_W-1:0] vn_a, vn_b, vt_a, vt_b, pn_a, pn_b;

    always_comb begin
        n1_pjm_lo = acir_pkg::PJM_W'(i_jn[SW-1:0]) * acir_pkg::PJM_W'(i_mu);
        n1_pjm_hi = acir_pkg::PJM_W'(i_jn[NW-1:SW]) * acir_pkg::PJM_W'(i_mu);

        n2_full = (acir_pkg::LIMF_W'(r1_pjm_hi) << SW) + acir_pkg::LIMF_W'(r1_pjm_lo);

        n3_ft = (acir_pkg::LIM_W'(r2_ft) < r2_limit) ? r2_ft : r2_limit[NW-1:0];

        // Lanes: normal impulse, friction impulse, correction; each for a then b.
        mag[0] = r3_jn;
        mag[1] = r3_ft;
        mag[2] = r3_corr;
        for (int l = 0; l < acir_pkg::LANES; l++) begin
            n4_lo[l] = acir_pkg::PP_W'((l % 2 == 0) ? r3_side.inv_a : r3_side.inv_b)
                       * acir_pkg::PP_W'(mag[l/2][SW-1:0]);
            n4_hi[l] = acir_pkg::PP_W'((l % 2 == 0) ? r3_side.inv_a : r3_side.inv_b)
                       * acir_pkg::PP_W'(mag[l/2][NW-1:SW]);
        end

        for (int l = 0; l < acir_pkg::LANES; l++) begin
            n5_sum[l] = (acir_pkg::PROD_W'(r4_hi[l]) << SW) + acir_pkg::PROD_W'(r4_lo[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_side   <= i_side;
            r1_pjm_lo <= n1_pjm_lo;
            r1_pjm_hi <= n1_pjm_hi;
            r1_jn     <= i_jn;
            r1_ft     <= i_ft;
            r1_corr   <= i_corr;

            r2_side   <= r1_side;
            r2_limit  <= n2_full[acir_pkg::LIMF_W-1:acir_pkg::FRAC_W];
            r2_jn     <= r1_jn;
            r2_ft     <= r1_ft;
            r2_corr   <= r1_corr;

            r3_side   <= r2_side;
            r3_jn     <= r2_jn;
            r3_ft     <= n3_ft;
            r3_corr   <= r2_corr;

            r4_side   <= r3_side;
            r4_lo     <= n4_lo;
            r4_hi     <= n4_hi;

            r5_side   <= r4_side;
            for (int l = 0; l < acir_pkg::LANES; l++) begin
                r5_mag[l] <= n5_sum[l][acir_pkg::PROD_W-1:acir_pkg::FRAC_W];
            end
        end
    end

    always_comb begin
        vel_en  = r5_side.ok && r5_side.approach;
        fric_on = vel_en && r5_side.fric_en;
        vn_a = vel_en  ? acir_pkg::sat_signed(r5_mag[0], !r5_side.nneg) : '0;
        vn_b = vel_en  ? acir_pkg::sat_signed(r5_mag[1], r5_side.nneg)  : '0;
        vt_a = fric_on ? acir_pkg::sat_signed(r5_mag[2], !r5_side.fneg) : '0;
        vt_b = fric_on ? acir_pkg::sat_signed(r5_mag[3], r5_side.fneg)  : '0;
        pn_a = r5_side.ok ? acir_pkg::sat_signed(r5_mag[4], !r5_side.nneg) : '0;
        pn_b = r5_side.ok ? acir_pkg::sat_signed(r5_mag[5], r5_side.nneg)  : '0;

        o_res.contact = r5_side.contact;
        if (r5_side.n_is_y) begin
            o_res.vel_a_dx = vt_a;
            o_res.vel_a_dy = vn_a;
            o_res.vel_b_dx = vt_b;
            o_res.vel_b_dy = vn_b;
            o_res.pos_a_dx = '0;
            o_res.pos_a_dy = pn_a;
            o_res.pos_b_dx = '0;
            o_res.pos_b_dy = pn_b;
        end else begin
            o_res.vel_a_dx = vn_a;
            o_res.vel_a_dy = vt_a;
            o_res.vel_b_dx = vn_b;
            o_res.vel_b_dy = vt_b;
            o_res.pos_a_dx = pn_a;
            o_res.pos_a_dy = '0;
            o_res.pos_b_dx = pn_b;
            o_res.pos_b_dy = '0;
        end
    end

    assign o_valid = r_v[4];

endmodule

@@ rtl/core/aabb_contact_impulse_resolver.sv @@
// Contact resolver for one pair of axis-aligned boxes, Q16.16 in and out.
//
// Input channel: i_valid with the pair fields; an item is taken on a rising
// edge with i_valid high and o_stall low. Output channel: o_valid with the
// contact flag and eight saturated deltas; the receiver holds i_stall high to
// keep the current item. Configuration: i_cfg_valid, i_cfg_index and
// i_cfg_data; o_cfg_ready is always high, so writes land on the edge.
//
// One item enters per cycle and one result leaves per cycle while no stall
// holds the pipeline. The three 50-stage dividers by the inverse-mass sum make
// up most of its depth, with a six-stage front end and a five-stage back end
// around them.
//
// When the receiver stalls, the result waiting at the output holds and the
// next one lands in a skid register; o_stall rises while that register is
// full and the whole pipeline freezes until the output drains.
// Reset empties the pipeline and loads the correction fraction (0.4) and the
// penetration slop (0.01).
module aabb_contact_impulse_resolver (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [31:0]                i_offset_x,
    input  logic signed [31:0]                i_offset_y,
    input  logic [30:0]                       i_reach_x,
    input  logic [30:0]                       i_reach_y,
    input  logic signed [31:0]                i_rel_vel_x,
    input  logic signed [31:0]                i_rel_vel_y,
    input  logic [30:0]                       i_inv_mass_a,
    input  logic [30:0]                       i_inv_mass_b,
    input  logic [16:0]                       i_bounce_a,
    input  logic [16:0]                       i_bounce_b,
    input  logic [18:0]                       i_grip_a,
    input  logic [18:0]                       i_grip_b,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_contact,
    output logic signed [31:0]                o_vel_a_dx,
    output logic signed [31:0]                o_vel_a_dy,
    output logic signed [31:0]                o_vel_b_dx,
    output logic signed [31:0]                o_vel_b_dy,
    output logic signed [31:0]                o_pos_a_dx,
    output logic signed [31:0]                o_pos_a_dy,
    output logic signed [31:0]                o_pos_b_dx,
    output logic signed [31:0]                o_pos_b_dy,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [acir_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [acir_pkg::CFG_W-1:0]        i_cfg_data
);

    logic                           adv;
    logic [acir_pkg::CFG_W-1:0]     r_percent, r_slop;

    logic                           prep_v;
    acir_pkg::t_prep                prep_d;

    logic [acir_pkg::NUM_W-1:0]     jn, ft_raw, corr;
    logic [acir_pkg::ROOT_W-1:0]    mu_raw;

    logic                           r_dly_v    [acir_pkg::DIV_LAT];
    acir_pkg::t_side                r_dly_side [acir_pkg::DIV_LAT];
    logic [acir_pkg::ROOT_W-1:0]    r_mu_dly   [acir_pkg::MU_PAD];

    logic                           post_v;
    acir_pkg::t_result              post_res;

    logic                           r_out_v, r_skid_v, n_out_v, n_skid_v, take;
    acir_pkg::t_result              r_out, r_skid, n_out, n_skid;

    assign adv         = !r_skid_v;
    assign o_stall     = r_skid_v;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_percent <= acir_pkg::PERCENT_RST;
            r_slop    <= acir_pkg::SLOP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                acir_pkg::CFG_PERCENT: r_percent <= i_cfg_data;
                acir_pkg::CFG_SLOP:    r_slop    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    acir_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_valid      (i_valid),
        .i_offset_x   (i_offset_x),
        .i_offset_y   (i_offset_y),
        .i_reach_x    (i_reach_x),
        .i_reach_y    (i_reach_y),
        .i_rel_vel_x  (i_rel_vel_x),
        .i_rel_vel_y  (i_rel_vel_y),
        .i_inv_mass_a (i_inv_mass_a),
        .i_inv_mass_b (i_inv_mass_b),
        .i_bounce_a   (i_bounce_a),
        .i_bounce_b   (i_bounce_b),
        .i_grip_a     (i_grip_a),
        .i_grip_b     (i_grip_b),
        .i_percent    (r_percent),
        .i_slop       (r_slop),
        .o_valid      (prep_v),
        .o_data       (prep_d)
    );

    acir_div #(.NUM_W(acir_pkg::NUM_W), .DEN_W(acir_pkg::DEN_W)) u_div_j (
        .i_clk (i_clk), .i_adv (adv), .i_num (prep_d.num_j), .i_den (prep_d.den),
        .o_quo (jn)
    );

    acir_div #(.NUM_W(acir_pkg::NUM_W), .DEN_W(acir_pkg::DEN_W)) u_div_f (
        .i_clk (i_clk), .i_adv (adv), .i_num (prep_d.num_f), .i_den (prep_d.den),
        .o_quo (ft_raw)
    );

    acir_div #(.NUM_W(acir_pkg::NUM_W), .DEN_W(acir_pkg::DEN_W)) u_div_c (
        .i_clk (i_clk), .i_adv (adv), .i_num (prep_d.num_c), .i_den (prep_d.den),
        .o_quo (corr)
    );

    acir_sqrt #(.IN_W(acir_pkg::GPROD_W)) u_sqrt (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_val  (prep_d.gprod),
        .o_root (mu_raw)
    );

    // Control and the friction root travel beside the dividers to stay aligned.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < acir_pkg::DIV_LAT; k++) begin
                r_dly_v[k] <= 1'b0;
            end
        end else if (adv) begin
            r_dly_v[0] <= prep_v;
            for (int k = 1; k < acir_pkg::DIV_LAT; k++) begin
                r_dly_v[k] <= r_dly_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dly_side[0] <= prep_d.side;
            for (int k = 1; k < acir_pkg::DIV_LAT; k++) begin
                r_dly_side[k] <= r_dly_side[k-1];
            end
            r_mu_dly[0] <= mu_raw;
            for (int k = 1; k < acir_pkg::MU_PAD; k++) begin
                r_mu_dly[k] <= r_mu_dly[k-1];
            end
        end
    end

    acir_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_dly_v[acir_pkg::DIV_LAT-1]),
        .i_side  (r_dly_side[acir_pkg::DIV_LAT-1]),
        .i_jn    (jn),
        .i_ft    (ft_raw),
        .i_corr  (corr),
        .i_mu    (r_mu_dly[acir_pkg::MU_PAD-1]),
        .o_valid (post_v),
        .o_res   (post_res)
    );

    // Output register with a one-item skid behind it.
    always_comb begin
        take     = r_out_v && !i_stall;
        n_out_v  = r_out_v;
        n_skid_v = r_skid_v;
        n_out    = r_out;
        n_skid   = r_skid;
        if (r_skid_v) begin
            if (take) begin
                n_out    = r_skid;
                n_skid_v = 1'b0;
            end
        end else if (post_v) begin
            if (!r_out_v || take) begin
                n_out   = post_res;
                n_out_v = 1'b1;
            end else begin
                n_skid   = post_res;
                n_skid_v = 1'b1;
            end
        end else if (take) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid    = r_out_v;
    assign o_contact  = r_out.contact;
    assign o_vel_a_dx = r_out.vel_a_dx;
    assign o_vel_a_dy = r_out.vel_a_dy;
    assign o_vel_b_dx = r_out.vel_b_dx;
    assign o_vel_b_dy = r_out.vel_b_dy;
    assign o_pos_a_dx = r_out.pos_a_dx;
    assign o_pos_a_dy = r_out.pos_a_dy;
    assign o_pos_b_dx = r_out.pos_b_dx;
    assign o_pos_b_dy = r_out.pos_b_dy;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds an item while the output register is empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_stall) |=> (r_skid_v && $stable(r_skid)))
        else $error("skid item changed while the output was stalled");

    a_skid_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (post_v && !r_skid_v && r_out_v && i_stall) |=> r_skid_v)
        else $error("finished item was not caught by the skid register");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && i_cfg_index == acir_pkg::CFG_PERCENT)
            |=> (r_percent == $past(i_cfg_data)))
        else $error("correction fraction write was lost");

endmodule
